// File: hw/rtl/ght_pkg.sv
// ght_pkg: shared types and constants of the generational handle table
// sizes of the slot store, slot entry layout, request and status codes, sequencer states
// no dependencies
package ght_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LINK_W = $clog2(SLOT_COUNT + 1);
  localparam logic [LINK_W-1:0] LINK_EMPTY = '1;

  typedef enum logic [1:0] {
    REQ_REG    = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [31:0]       gen;
    logic              busy;
    logic [LINK_W-1:0] link;
    logic [31:0]       w0;
    logic [31:0]       w1;
  } entry_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } chk_t;

endpackage

// File: hw/rtl/ght_req_if.sv
// ght_req_if: request channel of the generational handle table
// valid/ready handshake with request type, handle and two payload words
// no dependencies
interface ght_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [63:0] handle_in;
  logic [31:0]        conn_ref;
  logic [31:0]        tls_ref;

  modport source (output valid, req_type, handle_in, conn_ref, tls_ref, input ready);
  modport sink (input valid, req_type, handle_in, conn_ref, tls_ref, output ready);
endinterface

// File: hw/rtl/ght_rsp_if.sv
// ght_rsp_if: response channel of the generational handle table
// valid/ready handshake with status, handle and two payload words
// no dependencies
interface ght_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] handle_out;
  logic [31:0]        conn_out;
  logic [31:0]        tls_out;

  modport source (output valid, status, handle_out, conn_out, tls_out, input ready);
  modport sink (input valid, status, handle_out, conn_out, tls_out, output ready);
endinterface

// File: hw/rtl/generational_handle_table.sv
// generational_handle_table: handle allocator over a fixed pool of slots
// sequencer, free list head, high-water mark, generation counter and output register
// depends on ght_pkg, ght_req_if, ght_rsp_if, ght_slot_store, ght_check
//
// usage:
//   req carries one request: register (two payload words), free or lookup (handle).
//   rsp carries one response per request: status, new handle, payload words.
//   a request is taken when req.valid and req.ready are high at a rising edge;
//   the slot store is read at that edge; then, in the check state, the entry is
//   checked, written back and the response loaded into the output register.
//   no new request is taken before the previous one has left its check state,
//   since the slot store read is registered and the check follows it.
//   req.ready is high whenever no request is in flight; a request may be taken
//   while the previous response still waits in the output register.
//   when the receiver stalls, the next request holds in its check cycle until
//   the output register frees, and req.ready stays low meanwhile.
//   reset (rst, synchronous) empties the free list and clears the high-water
//   mark and the generation counter; the slot store needs no clearing, since
//   only entries of slots below the high-water mark are ever used.
module generational_handle_table (
  input logic      clk,
  input logic      rst,
  ght_req_if.sink  req,
  ght_rsp_if.source rsp
);

  ght_pkg::state_t state, state_next;

  logic [1:0]         req_type_r;
  logic signed [63:0] handle_r;
  logic [31:0]        conn_r;
  logic [31:0]        tls_r;

  logic [ght_pkg::LINK_W-1:0] free_top, free_top_next;
  logic [ght_pkg::LINK_W-1:0] high_water, high_water_next;
  logic [31:0]                gen_counter, gen_counter_next;
  logic [31:0]                gen_inc;

  logic               out_valid;
  ght_pkg::status_t   out_status, out_status_next;
  logic signed [63:0] out_handle, out_handle_next;
  logic [31:0]        out_conn, out_conn_next;
  logic [31:0]        out_tls, out_tls_next;

  logic                       accept;
  logic                       out_free;
  logic                       load;
  logic [31:0]                handle_idx;
  logic [ght_pkg::SLOT_W-1:0] rd_addr;
  ght_pkg::entry_t            rd_data;
  logic                       wr_en;
  logic [ght_pkg::SLOT_W-1:0] wr_addr;
  ght_pkg::entry_t            wr_data;
  ght_pkg::chk_t              chk;
  logic [ght_pkg::SLOT_W-1:0] alloc_slot;

  ght_slot_store u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ght_check u_check (
    .handle     (handle_r),
    .high_water (high_water),
    .entry      (rd_data),
    .chk        (chk)
  );

  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign handle_idx = req.handle_in[31:0] - 32'd1;
  assign rd_addr    = (req.req_type == ght_pkg::REQ_REG) ? free_top[ght_pkg::SLOT_W-1:0]
                                                          : handle_idx[ght_pkg::SLOT_W-1:0];
  assign gen_inc    = (gen_counter == 32'hffff_ffff) ? 32'd1 : gen_counter + 32'd1;

  always_comb begin
    state_next = state;
    case (state)
      ght_pkg::S_IDLE: begin
        if (req.valid) state_next = ght_pkg::S_EXEC;
      end
      ght_pkg::S_EXEC: begin
        if (out_free) state_next = ght_pkg::S_IDLE;
      end
      default: state_next = ght_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready        = (state == ght_pkg::S_IDLE);
    load             = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = chk.slot;
    wr_data          = rd_data;
    alloc_slot       = high_water[ght_pkg::SLOT_W-1:0];
    free_top_next    = free_top;
    high_water_next  = high_water;
    gen_counter_next = gen_counter;
    out_status_next  = ght_pkg::ST_BAD;
    out_handle_next  = -64'sd1;
    out_conn_next    = 32'd0;
    out_tls_next     = 32'd0;
    if (state == ght_pkg::S_EXEC && out_free) begin
      load = 1'b1;
      case (ght_pkg::req_t'(req_type_r))
        ght_pkg::REQ_REG: begin
          if (free_top < ght_pkg::LINK_W'(ght_pkg::SLOT_COUNT)) begin
            alloc_slot    = free_top[ght_pkg::SLOT_W-1:0];
            free_top_next = rd_data.link;
            wr_en         = 1'b1;
          end else if (high_water < ght_pkg::LINK_W'(ght_pkg::SLOT_COUNT)) begin
            alloc_slot      = high_water[ght_pkg::SLOT_W-1:0];
            high_water_next = high_water + ght_pkg::LINK_W'(1);
            wr_en           = 1'b1;
          end else begin
            out_status_next = ght_pkg::ST_FULL;
          end
          if (wr_en) begin
            gen_counter_next = gen_inc;
            wr_addr          = alloc_slot;
            wr_data          = '{gen: gen_inc, busy: 1'b1, link: ght_pkg::LINK_EMPTY,
                                 w0: conn_r, w1: tls_r};
            out_status_next  = ght_pkg::ST_OK;
            out_handle_next  = {gen_inc, 32'(alloc_slot) + 32'd1};
          end
        end
        ght_pkg::REQ_FREE: begin
          if (chk.ok) begin
            wr_en           = 1'b1;
            wr_data         = '{gen: rd_data.gen, busy: 1'b0, link: free_top,
                                w0: 32'd0, w1: 32'd0};
            free_top_next   = ght_pkg::LINK_W'(chk.slot);
            out_status_next = ght_pkg::ST_OK;
            out_conn_next   = rd_data.w0;
            out_tls_next    = rd_data.w1;
          end
        end
        ght_pkg::REQ_LOOKUP: begin
          if (chk.ok) begin
            out_status_next = ght_pkg::ST_OK;
            out_conn_next   = rd_data.w0;
            out_tls_next    = rd_data.w1;
          end
        end
        default: begin
          out_status_next = ght_pkg::ST_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ght_pkg::S_IDLE;
      free_top    <= ght_pkg::LINK_EMPTY;
      high_water  <= '0;
      gen_counter <= 32'd0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      free_top    <= free_top_next;
      high_water  <= high_water_next;
      gen_counter <= gen_counter_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= req.req_type;
      handle_r   <= req.handle_in;
      conn_r     <= req.conn_ref;
      tls_r      <= req.tls_ref;
    end
    if (load) begin
      out_status <= out_status_next;
      out_handle <= out_handle_next;
      out_conn   <= out_conn_next;
      out_tls    <= out_tls_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.handle_out = out_handle;
  assign rsp.conn_out   = out_conn;
  assign rsp.tls_out    = out_tls;

  // free list head is either empty or a real slot
  a_free_top_range: assert property (@(posedge clk) disable iff (rst)
    (free_top == ght_pkg::LINK_EMPTY) || (free_top < ght_pkg::LINK_W'(ght_pkg::SLOT_COUNT)))
    else $error("free list head out of range");

  a_high_water_range: assert property (@(posedge clk) disable iff (rst)
    high_water <= ght_pkg::LINK_W'(ght_pkg::SLOT_COUNT))
    else $error("high-water mark beyond slot count");

  // full is only reported once every slot has been used
  a_full_means_exhausted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ght_pkg::ST_FULL)
      |-> (high_water == ght_pkg::LINK_W'(ght_pkg::SLOT_COUNT)))
    else $error("full reported with unused slots left");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ght_pkg::S_EXEC) && !req.ready)
    else $error("request not taken into the check cycle");

  // an allocated handle never carries generation zero
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    (load && wr_en && ght_pkg::req_t'(req_type_r) == ght_pkg::REQ_REG) |-> (gen_inc != 32'd0))
    else $error("generation zero handed out");

endmodule

// File: hw/rtl/ght_slot_store.sv
// ght_slot_store: per-slot generation, in-use bit, free-list link and payload words
// one write port and one registered read port; depends on ght_pkg
module ght_slot_store (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [ght_pkg::SLOT_W-1:0] rd_addr,
  output ght_pkg::entry_t            rd_data,
  input  logic                       wr_en,
  input  logic [ght_pkg::SLOT_W-1:0] wr_addr,
  input  ght_pkg::entry_t            wr_data
);

  ght_pkg::entry_t mem [ght_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ght_check.sv
// ght_check: handle validation against the high-water mark and the slot entry read back
// compares sign, slot range, in-use bit and generation; depends on ght_pkg
module ght_check (
  input  logic signed [63:0]         handle,
  input  logic [ght_pkg::LINK_W-1:0] high_water,
  input  ght_pkg::entry_t            entry,
  output ght_pkg::chk_t              chk
);

  logic [31:0] idx;

  assign idx = handle[31:0] - 32'd1;

  always_comb begin
    chk.slot = idx[ght_pkg::SLOT_W-1:0];
    chk.ok   = (handle != 64'sd0) && !handle[63] && (handle[31:0] != 32'd0)
               && (idx < 32'(high_water)) && entry.busy && (entry.gen == handle[63:32]);
  end

endmodule
